// ----- src/mbe_pkg.sv -----
package mbe_pkg;

  // fixed field widths
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // arithmetic defaults
  localparam int unsigned FRAC_BITS_DEF  = 28;
  localparam int unsigned ESCAPE_MAG_SQ  = 4;
  localparam int unsigned ITER_BITS      = 16;
  localparam logic [CNT_W-1:0] ITER_MASK =
    (ITER_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((1 << ITER_BITS) - 1);

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // front stage product: 18 bit signed coordinate times 32 bit signed step
  localparam int unsigned PROD_W = 50;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_REAL  = 3'd0,
    CFG_MIN_IMAG  = 3'd1,
    CFG_STEP_REAL = 3'd2,
    CFG_STEP_IMAG = 3'd3,
    CFG_MAX_ITER  = 3'd4,
    CFG_OFFSET_X  = 3'd5,
    CFG_OFFSET_Y  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] min_real;
    logic signed [WORD_W-1:0] min_imag;
    logic        [STEP_W-1:0] step_real;
    logic        [STEP_W-1:0] step_imag;
    logic        [CNT_W-1:0]  iter_limit;
    logic signed [OFS_W-1:0]  offset_x;
    logic signed [OFS_W-1:0]  offset_y;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [CNT_W-1:0]         iteration_count;
    logic                     escaped;
    logic signed [WORD_W-1:0] final_real;
    logic signed [WORD_W-1:0] final_imag;
  } result_t;

  // point c handed from front to back
  typedef struct packed {
    logic signed [WORD_W-1:0] c_real;
    logic signed [WORD_W-1:0] c_imag;
  } point_t;

  typedef enum logic [1:0] {
    ITER_IDLE,
    ITER_MUL,
    ITER_UPD,
    ITER_DONE
  } iter_state_e;

  // clamp a wide signed value to the signed 32 bit range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

// ----- src/mbe_front.sv -----
module mbe_front
  import mbe_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_data_i,
  output logic   pt_valid_o,
  input  logic   pt_ready_i,
  output point_t pt_o
);

  logic                     s1_v_q, s1_v_d;
  logic                     s2_v_q, s2_v_d;
  logic signed [PROD_W-1:0] prod_r_q, prod_i_q;
  point_t                   pt_q;
  logic signed [17:0]       sum_x, sum_y;
  logic signed [PROD_W-1:0] prod_r_d, prod_i_d;
  logic                     s2_free, s1_adv, in_acc;

  // pipeline flow control
  assign s2_free    = !s2_v_q || pt_ready_i;
  assign s1_adv     = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_v_d     = in_acc || (s1_v_q && !s2_free);
  assign s2_v_d     = s1_adv || (s2_v_q && !pt_ready_i);

  // panned coordinate times step
  assign sum_x    = $signed({6'b0, in_data_i.pixel_x}) + 18'(cfg_i.offset_x);
  assign sum_y    = $signed({6'b0, in_data_i.pixel_y}) + 18'(cfg_i.offset_y);
  assign prod_r_d = sum_x * $signed({1'b0, cfg_i.step_real});
  assign prod_i_d = sum_y * $signed({1'b0, cfg_i.step_imag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  // stage one: products, stage two: add view origin and clamp
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prod_r_q <= prod_r_d;
      prod_i_q <= prod_i_d;
    end
    if (s1_adv) begin
      pt_q.c_real <= sat_word(66'(prod_r_q) + 66'(cfg_i.min_real));
      pt_q.c_imag <= sat_word(66'(prod_i_q) + 66'(cfg_i.min_imag));
    end
  end

  assign pt_valid_o = s2_v_q;
  assign pt_o       = pt_q;

endmodule

// ----- src/mbe_fifo.sv -----
module mbe_fifo
  import mbe_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  point_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output point_t pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  point_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0]   count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill level stays within the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_QW'(QUEUE_DEPTH))
    else $error("queue fill level above depth");

endmodule

// ----- src/mbe_iter.sv -----
module mbe_iter
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] max_iter_i,
  input  logic             pt_valid_i,
  output logic             pt_ready_o,
  input  point_t           pt_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_o
);

  localparam logic [64:0] MAG_LIMIT = 65'(ESCAPE_MAG_SQ) << FRAC_BITS;

  iter_state_e              state_q, state_d;
  logic signed [WORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic        [CNT_W-1:0]  cnt_q;
  logic signed [63:0]       prr_q, pii_q, pri_q;
  logic                     out_valid_q;
  result_t                  out_q;

  logic                     load_pt, do_mul, do_upd, load_out;
  logic        [64:0]       mag;
  logic signed [64:0]       diff, diff_sh;
  logic signed [63:0]       cross_sh;
  logic signed [65:0]       nr_sum, ni_sum;

  // magnitude from floored squares, and the next z
  assign mag      = ({1'b0, prr_q} >> FRAC_BITS) + ({1'b0, pii_q} >> FRAC_BITS);
  assign diff     = 65'(prr_q) - 65'(pii_q);
  assign diff_sh  = diff >>> FRAC_BITS;
  assign cross_sh = pri_q >>> (FRAC_BITS - 1);
  assign nr_sum   = 66'(diff_sh) + 66'(cr_q);
  assign ni_sum   = 66'(cross_sh) + 66'(ci_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    pt_ready_o = 1'b0;
    load_pt    = 1'b0;
    do_mul     = 1'b0;
    do_upd     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ITER_IDLE: begin
        pt_ready_o = 1'b1;
        if (pt_valid_i) begin
          load_pt = 1'b1;
          state_d = ITER_MUL;
        end
      end
      ITER_MUL: begin
        if (cnt_q == max_iter_i) begin
          state_d = ITER_DONE;
        end else begin
          do_mul  = 1'b1;
          state_d = ITER_UPD;
        end
      end
      ITER_UPD: begin
        if (mag >= MAG_LIMIT) begin
          state_d = ITER_DONE;
        end else begin
          do_upd  = 1'b1;
          state_d = ITER_MUL;
        end
      end
      ITER_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ITER_IDLE;
        end
      end
      default: state_d = ITER_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ITER_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // iteration datapath
  always_ff @(posedge clk_i) begin
    if (load_pt) begin
      cr_q  <= pt_i.c_real;
      ci_q  <= pt_i.c_imag;
      zr_q  <= '0;
      zi_q  <= '0;
      cnt_q <= '0;
    end
    if (do_mul) begin
      prr_q <= zr_q * zr_q;
      pii_q <= zi_q * zi_q;
      pri_q <= zr_q * zi_q;
    end
    if (do_upd) begin
      zr_q  <= sat_word(nr_sum);
      zi_q  <= sat_word(ni_sum);
      cnt_q <= cnt_q + 1'b1;
    end
    if (load_out) begin
      out_q.iteration_count <= cnt_q & ITER_MASK;
      out_q.escaped         <= (cnt_q < max_iter_i);
      out_q.final_real      <= zr_q;
      out_q.final_imag      <= zi_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an update step only follows a count below the limit
  a_upd_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ITER_UPD) |-> (cnt_q < max_iter_i))
    else $error("update step with count at the limit");

  // the count never passes the limit while a point is in work
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ITER_IDLE) |-> (cnt_q <= max_iter_i))
    else $error("iteration count above limit");

  // a finished point always reaches the output register
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && (state_q == ITER_IDLE)))
    else $error("result not loaded into output register");

endmodule

// ----- src/mandelbrot_escape_time_unit.sv -----
// path: 2 front stages and the queue, then the iteration engine, which squares z
//   in a multiply state and updates it in an update state, until the limit
//   is reached or z escapes; the single engine takes a new pixel only when idle,
//   so it sets the pace, and the front runs ahead via the queue
// reset: asynchronous active low, clears control and loads the default view
module mandelbrot_escape_time_unit
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pixel_t                in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_data_o
);

  cfg_t   cfg_q;
  logic   fr_valid, fr_ready, bk_valid, bk_ready;
  point_t fr_pt, bk_pt;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_real   <= 32'shE000_0000;
      cfg_q.min_imag   <= 32'shF000_0000;
      cfg_q.step_real  <= 31'd196608;
      cfg_q.step_imag  <= 31'd196608;
      cfg_q.iter_limit <= 16'd256;
      cfg_q.offset_x   <= '0;
      cfg_q.offset_y   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_REAL:  cfg_q.min_real   <= cfg_wdata_i;
        CFG_MIN_IMAG:  cfg_q.min_imag   <= cfg_wdata_i;
        CFG_STEP_REAL: cfg_q.step_real  <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_IMAG: cfg_q.step_imag  <= cfg_wdata_i[STEP_W-1:0];
        CFG_MAX_ITER:  cfg_q.iter_limit <= cfg_wdata_i[CNT_W-1:0];
        CFG_OFFSET_X:  cfg_q.offset_x   <= cfg_wdata_i[OFS_W-1:0];
        CFG_OFFSET_Y:  cfg_q.offset_y   <= cfg_wdata_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel to point mapping
  mbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pt_valid_o (fr_valid),
    .pt_ready_i (fr_ready),
    .pt_o       (fr_pt)
  );

  // decoupling queue
  mbe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_pt),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_pt)
  );

  // escape time iteration
  mbe_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_iter_i  (cfg_q.iter_limit),
    .pt_valid_i  (bk_valid),
    .pt_ready_o  (bk_ready),
    .pt_i        (bk_pt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule
